[sv/oetr_pkg.sv]
`timescale 1ns / 1ps

package oetr_pkg;

    localparam int RING_DEPTH = 64;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int REQ_W      = 16;
    localparam int TOTAL_W    = 7;

    // depth of the queue between front and back
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic KIND_LOG  = 1'b0;
    localparam logic KIND_DUMP = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic                   kind;
        logic signed [15:0]     proc_id;
        logic [7:0]             event_code;
        logic signed [7:0]      outcome_code;
        logic [REQ_W-1:0]       max_count;
    } t_in_item;

    typedef struct packed {
        logic [1:0]             status;
        logic signed [15:0]     entry_pid;
        logic [7:0]             entry_event;
        logic signed [7:0]      entry_outcome;
        logic [TOTAL_W-1:0]     total_copied;
        logic                   last;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0]     pid;
        logic [7:0]             event_code;
        logic signed [7:0]      outcome_code;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic                   en;
        logic [IDX_W-1:0]       addr;
        t_entry                 data;
    } t_ram_wr;

    typedef struct packed {
        logic                   en;
        logic [IDX_W-1:0]       addr;
    } t_ram_rd;

    // classified dump request
    typedef struct packed {
        logic [1:0]             status;
        logic [IDX_W-1:0]       start;
        logic [CNT_W-1:0]       count;
    } t_cmd;

    typedef struct packed {
        logic [1:0]             status;
        logic [CNT_W-1:0]       total;
        logic                   last;
    } t_rd_meta;

endpackage

[sv/oetr_ram.sv]
`timescale 1ns / 1ps

module oetr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/oetr_front.sv]
`timescale 1ns / 1ps

module oetr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  oetr_pkg::t_in_item i_item,
    input  logic              i_dump_pending,
    input  logic              i_q_full,
    output oetr_pkg::t_ram_wr o_wr,
    output logic              o_push,
    output oetr_pkg::t_cmd    o_cmd
);
    import oetr_pkg::*;

    logic [IDX_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic             is_log;
    logic             accept;
    logic             ring_full;
    logic [CNT_W-1:0] head_ext;

    assign is_log    = (i_item.kind == KIND_LOG);
    assign ring_full = (r_fill == CNT_W'(RING_DEPTH));
    // once full, a log would overwrite entries that a queued dump still has to read
    assign o_stall   = is_log ? (i_dump_pending && ring_full) : i_q_full;
    assign accept    = i_valid && !o_stall;

    assign o_wr.en                = accept && is_log;
    assign o_wr.addr              = r_head;
    assign o_wr.data.pid          = i_item.proc_id;
    assign o_wr.data.event_code   = i_item.event_code;
    assign o_wr.data.outcome_code = i_item.outcome_code;

    assign o_push   = accept && !is_log;
    assign head_ext = CNT_W'(r_head);

    always_comb begin
        o_cmd.status = ST_OK;
        o_cmd.count  = r_fill;
        o_cmd.start  = IDX_W'((CNT_W'(RING_DEPTH) - r_fill) + head_ext);
        if (head_ext >= r_fill) begin
            o_cmd.start = IDX_W'(head_ext - r_fill);
        end
        if (i_item.max_count < REQ_W'(r_fill)) begin
            o_cmd.count = i_item.max_count[CNT_W-1:0];
        end
        // zero request is checked before empty ring
        if (i_item.max_count == '0) begin
            o_cmd.status = ST_INVALID;
        end else if (r_fill == '0) begin
            o_cmd.status = ST_EMPTY;
        end
    end

    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        if (o_wr.en) begin
            if (r_head == IDX_W'(RING_DEPTH - 1)) begin
                n_head = '0;
            end else begin
                n_head = r_head + 1'b1;
            end
            if (!ring_full) begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
        end
    end

endmodule

[sv/oetr_cmd_q.sv]
`timescale 1ns / 1ps

module oetr_cmd_q (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  oetr_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output oetr_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import oetr_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count, n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[sv/oetr_back.sv]
`timescale 1ns / 1ps

module oetr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  oetr_pkg::t_cmd     i_cmd,
    output logic               o_q_pop,
    output oetr_pkg::t_ram_rd  o_rd,
    input  oetr_pkg::t_entry   i_rd_data,
    output logic               o_busy,
    output logic               o_valid,
    input  logic               i_stall,
    output oetr_pkg::t_out_item o_item
);
    import oetr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_addr, n_addr;
    logic [CNT_W-1:0] r_left, n_left;
    logic [CNT_W-1:0] r_total, n_total;
    logic [1:0]       r_status, n_status;

    logic             r_rd_valid;
    t_rd_meta         r_rd_meta, n_rd_meta;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;
    logic             r_skid_valid, n_skid_valid;
    t_out_item        r_skid, n_skid;

    logic             pop;
    logic [1:0]       occ;
    logic             can_issue;
    logic             issue;
    logic             issue_last;
    t_out_item        fresh;

    assign pop = r_out_valid && !i_stall;
    assign occ = {1'b0, r_out_valid} + {1'b0, r_skid_valid} + {1'b0, r_rd_valid};
    // a read is issued only when a buffer slot is sure to be free when its data lands
    assign can_issue  = (occ < 2'd2) || ((occ == 2'd2) && pop);
    assign issue      = (r_state == S_RUN) && can_issue;
    assign issue_last = (r_left == CNT_W'(1));

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign o_busy  = (r_state == S_RUN);
    assign o_rd.en   = issue && (r_status == ST_OK);
    assign o_rd.addr = r_addr;

    assign n_rd_meta.status = r_status;
    assign n_rd_meta.total  = r_total;
    assign n_rd_meta.last   = issue_last;

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_left   = r_left;
        n_total  = r_total;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state  = S_RUN;
                    n_addr   = i_cmd.start;
                    n_status = i_cmd.status;
                    if (i_cmd.status == ST_OK) begin
                        n_left  = i_cmd.count;
                        n_total = i_cmd.count;
                    end else begin
                        n_left  = CNT_W'(1);
                        n_total = '0;
                    end
                end
            end
            S_RUN: begin
                if (issue) begin
                    n_left = r_left - 1'b1;
                    if (r_addr == IDX_W'(RING_DEPTH - 1)) begin
                        n_addr = '0;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                    if (issue_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        fresh.status       = r_rd_meta.status;
        fresh.entry_pid    = '0;
        fresh.entry_event  = '0;
        fresh.entry_outcome = '0;
        fresh.total_copied = TOTAL_W'(r_rd_meta.total);
        fresh.last         = r_rd_meta.last;
        if (r_rd_meta.status == ST_OK) begin
            fresh.entry_pid     = i_rd_data.pid;
            fresh.entry_event   = i_rd_data.event_code;
            fresh.entry_outcome = i_rd_data.outcome_code;
        end
    end

    // output register with a skid stage behind it
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                n_out       = r_skid;
                n_out_valid = 1'b1;
                if (r_rd_valid) begin
                    n_skid = fresh;
                end else begin
                    n_skid_valid = 1'b0;
                end
            end else begin
                n_out_valid = r_rd_valid;
                n_out       = fresh;
            end
        end else if (r_rd_valid) begin
            n_skid       = fresh;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_left    <= n_left;
        r_total   <= n_total;
        r_status  <= n_status;
        r_rd_meta <= n_rd_meta;
        r_out     <= n_out;
        r_skid    <= n_skid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rd_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rd_valid   <= issue;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

[sv/overwriting_event_trace_ring.sv]
`timescale 1ns / 1ps

// Event trace ring of RING_DEPTH entries that overwrites the oldest entry once full.
// A log request gives no result; logs are taken every cycle,
// except that a log which would overwrite a full ring stalls while a dump still has
// entries to read. A dump request is classified at once and queued (two deep); the
// back end then streams its min(fill, max_count) oldest entries at one result per
// cycle while i_stall is low, set by the single read port of the ring memory; it
// takes the next queued dump only once it is back in idle. A zero request or an
// empty ring gives a single status result with last set.
module overwriting_event_trace_ring (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  oetr_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output oetr_pkg::t_out_item o_item
);
    import oetr_pkg::*;

    t_ram_wr ram_wr;
    t_ram_rd ram_rd;
    t_entry  rd_data;
    logic    push;
    t_cmd    push_cmd;
    logic    q_full;
    logic    q_valid;
    t_cmd    q_cmd;
    logic    q_pop;
    logic    back_busy;
    logic    dump_pending;

    assign dump_pending = q_valid || back_busy;

    oetr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_item         (i_item),
        .i_dump_pending (dump_pending),
        .i_q_full       (q_full),
        .o_wr           (ram_wr),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    oetr_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    oetr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr.en),
        .i_wr_addr (ram_wr.addr),
        .i_wr_data (ram_wr.data),
        .i_rd_en   (ram_rd.en),
        .i_rd_addr (ram_rd.addr),
        .o_rd_data (rd_data)
    );

    oetr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .o_q_pop   (q_pop),
        .o_rd      (ram_rd),
        .i_rd_data (rd_data),
        .o_busy    (back_busy),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_item    (o_item)
    );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import oetr_pkg::*;

    localparam int IDLE_LIMIT = 1000;
    localparam int END_CYCLES = 20;
    localparam int N_RANDOM   = 450;

    typedef struct {
        t_in_item    req;
        int unsigned gap;
        bit          drain;
    } t_queued_req;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      tx_valid = 1'b0;
    t_in_item  tx_item  = '0;
    logic      rx_stall = 1'b0;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_item;

    t_queued_req queued_reqs[$];
    t_out_item   due_results[$];

    // trace ring as the block should hold it
    t_entry            trace_mem [RING_DEPTH];
    logic [IDX_W-1:0]  wr_ptr = '0;
    logic [CNT_W-1:0]  fill   = '0;

    int unsigned n_due = 0;
    int unsigned n_seen = 0;
    int unsigned rx_wait = 0;
    int unsigned idle_cycles = 0;
    int unsigned errs = 0;
    bit          rx_calm = 1'b0;
    bit          tx_calm = 1'b0;

    overwriting_event_trace_ring uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (tx_valid),
        .o_stall (o_stall),
        .i_item  (tx_item),
        .o_valid (o_valid),
        .i_stall (rx_stall),
        .o_item  (o_item)
    );

    always #5 i_clk = ~i_clk;

    // logs update the ring, dumps queue what the block must return
    function automatic int apply_trace_request(t_in_item r);
        t_out_item        res;
        int               n;
        logic [IDX_W-1:0] rd;
        if (r.kind == KIND_LOG) begin
            trace_mem[wr_ptr] = '{r.proc_id, r.event_code, r.outcome_code};
            wr_ptr = wr_ptr + 1'b1;
            if (fill < RING_DEPTH)
                fill = fill + 1'b1;
            return 0;
        end
        res = '0;
        res.last = 1'b1;
        if (r.max_count == 0) begin
            res.status = ST_INVALID;
            due_results.push_back(res);
            return 1;
        end
        if (fill == 0) begin
            res.status = ST_EMPTY;
            due_results.push_back(res);
            return 1;
        end
        n = (int'(fill) < int'(r.max_count)) ? int'(fill) : int'(r.max_count);
        // oldest entry sits fill slots behind the write pointer
        rd = wr_ptr - IDX_W'(fill);
        for (int i = 0; i < n; i++) begin
            res.status        = ST_OK;
            res.entry_pid     = trace_mem[rd].pid;
            res.entry_event   = trace_mem[rd].event_code;
            res.entry_outcome = trace_mem[rd].outcome_code;
            res.total_copied  = TOTAL_W'(n);
            res.last          = (i == n - 1);
            due_results.push_back(res);
            rd = rd + 1'b1;
        end
        return n;
    endfunction

    task automatic flag(string msg);
        errs++;
        if (errs <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        if (due_results.size() == 0) begin
            flag($sformatf("unexpected result: %p", got));
            return;
        end
        want = due_results.pop_front();
        if (got.status !== want.status)
            flag($sformatf("status: expected %0d, got %0d", want.status, got.status));
        if (got.entry_pid !== want.entry_pid)
            flag($sformatf("entry_pid: expected %0d, got %0d", want.entry_pid, got.entry_pid));
        if (got.entry_event !== want.entry_event)
            flag($sformatf("entry_event: expected %0h, got %0h",
                           want.entry_event, got.entry_event));
        if (got.entry_outcome !== want.entry_outcome)
            flag($sformatf("entry_outcome: expected %0d, got %0d",
                           want.entry_outcome, got.entry_outcome));
        if (got.total_copied !== want.total_copied)
            flag($sformatf("total_copied: expected %0d, got %0d",
                           want.total_copied, got.total_copied));
        if (got.last !== want.last)
            flag($sformatf("last: expected %0b, got %0b", want.last, got.last));
    endtask

    function automatic t_in_item make_log(logic signed [15:0] pid, logic [7:0] ev,
                                          logic signed [7:0] oc);
        t_in_item r;
        r.kind         = KIND_LOG;
        r.proc_id      = pid;
        r.event_code   = ev;
        r.outcome_code = oc;
        r.max_count    = 16'($urandom);
        return r;
    endfunction

    function automatic t_in_item make_dump(logic [15:0] mx);
        t_in_item r;
        r.kind         = KIND_DUMP;
        r.proc_id      = 16'($urandom);
        r.event_code   = 8'($urandom);
        r.outcome_code = 8'($urandom);
        r.max_count    = mx;
        return r;
    endfunction

    task automatic push_req(t_in_item r, bit drain);
        t_queued_req q;
        q.req   = r;
        q.gap   = tx_calm ? 0 : $urandom_range(0, 9);
        q.drain = drain;
        queued_reqs.push_back(q);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tx_valid <= 1'b0;
        end else if (!tx_valid || !o_stall) begin
            if (queued_reqs.size() != 0 && queued_reqs[0].gap != 0) begin
                queued_reqs[0].gap = queued_reqs[0].gap - 1;
                tx_valid <= 1'b0;
            end else if (queued_reqs.size() != 0 &&
                         (!queued_reqs[0].drain || (!tx_valid && n_due == n_seen))) begin
                tx_item  <= queued_reqs[0].req;
                tx_valid <= 1'b1;
                void'(queued_reqs.pop_front());
            end else begin
                tx_valid <= 1'b0;
            end
        end
    end

    // monitor: prediction first so a same-edge request is already accounted for
    always @(posedge i_clk) begin : monitor
        int unsigned w;
        if (!i_rst_n) begin
            wr_ptr = '0;
            fill   = '0;
            rx_stall <= 1'b0;
            rx_wait  <= 0;
            n_due    <= 0;
            n_seen   <= 0;
        end else begin
            if (tx_valid && !o_stall)
                n_due <= n_due + apply_trace_request(tx_item);
            if (o_valid && !rx_stall) begin
                check_result(o_item);
                n_seen <= n_seen + 1;
                if ($urandom_range(0, 31) == 0)
                    rx_calm <= !rx_calm;
                w = rx_calm ? 0 : $urandom_range(0, 9);
                rx_stall <= (w != 0);
                rx_wait  <= w;
            end else if (rx_stall) begin
                if (rx_wait <= 1)
                    rx_stall <= 1'b0;
                rx_wait <= rx_wait - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (tx_valid && !o_stall) || (o_valid && !rx_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned log_pct;
        logic [15:0] mx;

        // empty ring, zero request checked before emptiness
        push_req(make_dump(16'd0), 1'b0);
        push_req(make_dump(16'd1), 1'b0);
        push_req(make_dump(16'hffff), 1'b0);
        // field extremes
        push_req(make_log(-16'sd1, 8'h00, -8'sd128), 1'b0);
        push_req(make_log(16'sd32767, 8'hff, 8'sd127), 1'b0);
        push_req(make_log(16'sd0, 8'h5a, 8'sd0), 1'b0);
        push_req(make_dump(16'd0), 1'b0);
        push_req(make_dump(16'd1), 1'b0);
        push_req(make_dump(16'd2), 1'b0);
        push_req(make_dump(16'hffff), 1'b0);
        // wait for the ring to go quiet before the next log
        push_req(make_log(16'sd1, 8'ha5, -8'sd1), 1'b1);
        push_req(make_dump(16'h8000), 1'b0);
        push_req(make_dump(16'd3), 1'b0);
        push_req(make_dump(16'h7fff), 1'b0);

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k % 50 == 0) begin
                // first stretch fills the ring well past wrap
                if (k < 100)
                    log_pct = 97;
                else
                    case ($urandom_range(0, 2))
                        0:       log_pct = 50;
                        1:       log_pct = 75;
                        default: log_pct = 90;
                    endcase
                tx_calm = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 99) < log_pct) begin
                push_req(make_log(($urandom_range(0, 7) == 0) ? -16'sd1
                                  : 16'($urandom_range(0, 32767)),
                                  8'($urandom), 8'($urandom)),
                         $urandom_range(0, 39) == 0);
            end else begin
                case ($urandom_range(0, 9))
                    0:       mx = 16'd0;
                    1:       mx = 16'($urandom);
                    2:       mx = 16'($urandom_range(63, 66));
                    default: mx = 16'($urandom_range(1, 70));
                endcase
                push_req(make_dump(mx), $urandom_range(0, 39) == 0);
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (queued_reqs.size() != 0 || tx_valid || n_seen != n_due)
            @(negedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);

        if (due_results.size() != 0)
            $display("%0d expected results never arrived", due_results.size());
        if (errs == 0 && due_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[overwriting_event_trace_ring.f]
sv/oetr_pkg.sv
sv/oetr_ram.sv
sv/oetr_front.sv
sv/oetr_cmd_q.sv
sv/oetr_back.sv
sv/overwriting_event_trace_ring.sv
verif/tb_top.sv
